// ===== rtl/event_cut_dual_histogram_defines.svh =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: assertion macros
// Concurrent check wrappers clocked on aclk. ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef EVENT_CUT_DUAL_HISTOGRAM_DEFINES_SVH
`define EVENT_CUT_DUAL_HISTOGRAM_DEFINES_SVH

`ifndef ASSERT_OFF
// Check while out of reset
`define ECDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check at every edge, reset included
`define ECDH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ECDH_ASSERT(lbl, prop, msg)
`define ECDH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/ecdh_pkg.sv =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: shared package
// Sizes, codes and item/command/result types used across the block.
// ----------------------------------------------------------------------------
package ecdh_pkg;

    // Histogram geometry
    localparam int NUM_BINS    = 75;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(NUM_BINS + 1);
    localparam int BIN_SCALE   = 50;

    // Field widths
    localparam int MASS_W     = 16;
    localparam int CUT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int RD_BIN_W   = 7;
    localparam int OUT_CNT_W  = 32;
    localparam int PROD_W     = 32;
    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;

    // Bin divider: remainder holds 50*mass and res<<BIN_W
    localparam int REM_W  = MASS_W + BIN_W;
    localparam int STEP_W = $clog2(BIN_W);

    // Command queue (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_EVENT = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASYM_LIMIT   = 3'd0,
        CFG_ETA_GAP      = 3'd1,
        CFG_SEPARATION   = 3'd2,
        CFG_ALPHA_LOW    = 3'd3,
        CFG_ALPHA_HIGH   = 3'd4,
        CFG_DIJET_RES    = 3'd5,
        CFG_FOURJET_RES  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] asym_limit;
        logic [CFG_W-1:0] eta_gap_limit;
        logic [CFG_W-1:0] separation_limit;
        logic [CFG_W-1:0] alpha_low;
        logic [CFG_W-1:0] alpha_high;
        logic [CFG_W-1:0] dijet_res_mass;
        logic [CFG_W-1:0] fourjet_res_mass;
    } cfg_t;

    typedef struct packed {
        action_t             action;
        logic [MASS_W-1:0]   fourjet_mass;
        logic [MASS_W-1:0]   avg_dijet_mass;
        logic [CUT_W-1:0]    mass_asymmetry;
        logic [CUT_W-1:0]    eta_gap;
        logic [CUT_W-1:0]    sep_first;
        logic [CUT_W-1:0]    sep_second;
        logic                which_hist;
        logic [RD_BIN_W-1:0] read_bin;
    } item_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [MASS_W-1:0]   avg_dijet_mass;
        logic [MASS_W-1:0]   fourjet_mass;
        logic                which_hist;
        logic [RD_BIN_W-1:0] read_bin;
    } cmd_t;

    typedef struct packed {
        logic                 accepted;
        logic [BIN_W-1:0]     dijet_bin;
        logic [BIN_W-1:0]     fourjet_bin;
        logic [OUT_CNT_W-1:0] bin_count;
    } result_t;

    // Saturating histogram increment
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Clamp a stored count to the reported width
    function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'(33'h0FFFF_FFFF)) ? '1 : w[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/ecdh_front.sv =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: front end
// Holds one input item with its ratio products and classifies it into a
// back-end command (count, read, clear or nothing).
// ----------------------------------------------------------------------------
module ecdh_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ecdh_pkg::item_t  s_item,
    input  ecdh_pkg::cfg_t   cfg,
    input  logic             q_full,
    output logic             q_push,
    output ecdh_pkg::cmd_t   q_cmd
);

    logic                         hold_valid_reg;
    ecdh_pkg::item_t              hold_item_reg;
    logic [ecdh_pkg::PROD_W-1:0]  prod_low_reg;
    logic [ecdh_pkg::PROD_W-1:0]  prod_high_reg;
    logic [ecdh_pkg::PROD_W-1:0]  avg_shifted;
    logic                         pass;
    logic                         take;

    assign s_tready = !hold_valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign q_push   = hold_valid_reg && !q_full;

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (take) begin
            hold_valid_reg <= 1'b1;
        end else if (q_push) begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Capture item and form the ratio bound products
    always_ff @(posedge aclk) begin
        if (take) begin
            hold_item_reg <= s_item;
            prod_low_reg  <= ecdh_pkg::PROD_W'(cfg.alpha_low) *
                             ecdh_pkg::PROD_W'(s_item.fourjet_mass);
            prod_high_reg <= ecdh_pkg::PROD_W'(cfg.alpha_high) *
                             ecdh_pkg::PROD_W'(s_item.fourjet_mass);
        end
    end

    // Apply the cuts; ratio test is avg*2^16 against alpha*four
    always_comb begin
        avg_shifted = {hold_item_reg.avg_dijet_mass, 16'h0000};
        pass = (hold_item_reg.mass_asymmetry < cfg.asym_limit) &&
               (hold_item_reg.eta_gap < cfg.eta_gap_limit) &&
               (hold_item_reg.sep_first < cfg.separation_limit) &&
               (hold_item_reg.sep_second < cfg.separation_limit) &&
               (hold_item_reg.fourjet_mass != '0) &&
               (avg_shifted > prod_low_reg) &&
               (avg_shifted < prod_high_reg);
    end

    // Build the command
    always_comb begin
        q_cmd.avg_dijet_mass = hold_item_reg.avg_dijet_mass;
        q_cmd.fourjet_mass   = hold_item_reg.fourjet_mass;
        q_cmd.which_hist     = hold_item_reg.which_hist;
        q_cmd.read_bin       = hold_item_reg.read_bin;
        unique case (hold_item_reg.action)
            ecdh_pkg::ACT_EVENT: begin
                q_cmd.kind = pass ? ecdh_pkg::CMD_COUNT : ecdh_pkg::CMD_NOP;
            end
            ecdh_pkg::ACT_READ: begin
                q_cmd.kind = ecdh_pkg::CMD_READ;
            end
            ecdh_pkg::ACT_CLEAR: begin
                q_cmd.kind = ecdh_pkg::CMD_CLEAR;
            end
            default: begin
                q_cmd.kind = ecdh_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/ecdh_queue.sv =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: command queue
// Small FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module ecdh_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ecdh_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output ecdh_pkg::cmd_t  dout,
    output logic            empty
);

    logic [ecdh_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ecdh_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ecdh_pkg::QCNT_W-1:0] count_reg;
    ecdh_pkg::cmd_t              slot_reg [ecdh_pkg::QUEUE_DEPTH];

    assign full  = (count_reg == ecdh_pkg::QCNT_W'(ecdh_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    // Pointers and fill count; pointers wrap at the power-of-two depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/ecdh_bindiv.sv =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: bin divider
// Restoring division of 50*mass by the resonance mass, one quotient bit per
// step, clamped to the overflow bin.
// ----------------------------------------------------------------------------
module ecdh_bindiv (
    input  logic                          aclk,
    input  logic                          start,
    input  logic                          step,
    input  logic [ecdh_pkg::MASS_W-1:0]   mass,
    input  logic [ecdh_pkg::MASS_W-1:0]   res_mass,
    output logic [ecdh_pkg::BIN_W-1:0]    bin
);

    logic [ecdh_pkg::REM_W-1:0] rem_reg;
    logic [ecdh_pkg::REM_W-1:0] dsh_reg;
    logic [ecdh_pkg::BIN_W-1:0] quo_reg;
    logic                       ovf_reg;
    logic [ecdh_pkg::REM_W-1:0] scaled;
    logic [ecdh_pkg::REM_W-1:0] res_ext;

    assign scaled  = ecdh_pkg::REM_W'(mass) * ecdh_pkg::REM_W'(ecdh_pkg::BIN_SCALE);
    assign res_ext = ecdh_pkg::REM_W'(res_mass);

    // Load on start, then subtract the shifted divisor bit by bit
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= scaled;
            dsh_reg <= res_ext << (ecdh_pkg::BIN_W - 1);
            quo_reg <= '0;
            // Quotient would not fit: zero divisor lands here too
            ovf_reg <= (scaled >= (res_ext << ecdh_pkg::BIN_W));
        end else if (step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[ecdh_pkg::BIN_W-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[ecdh_pkg::BIN_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Clamp to the overflow bin
    assign bin = (ovf_reg || (quo_reg >= ecdh_pkg::BIN_W'(ecdh_pkg::NUM_BINS))) ?
                 ecdh_pkg::BIN_W'(ecdh_pkg::NUM_BINS) : quo_reg;

endmodule

// ===== rtl/ecdh_back.sv =====
// ----------------------------------------------------------------------------
// Event cut dual histogram: back end
// Pops commands, finds the bins, does the histogram read-modify-write or
// read, clears, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ecdh_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ecdh_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  ecdh_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ecdh_pkg::result_t m_result
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MRD  = 5'b00100,
        ST_MUSE = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    ecdh_pkg::cmd_t                    cmd_reg;
    logic [ecdh_pkg::STEP_W-1:0]       step_reg;
    ecdh_pkg::result_t                 res_reg;
    ecdh_pkg::result_t                 out_reg;
    logic                              out_valid_reg;

    logic [ecdh_pkg::COUNT_WIDTH-1:0]  dj_mem [ecdh_pkg::NUM_BINS + 1];
    logic [ecdh_pkg::COUNT_WIDTH-1:0]  fj_mem [ecdh_pkg::NUM_BINS + 1];
    logic [ecdh_pkg::NUM_BINS:0]       dj_vld_reg;
    logic [ecdh_pkg::NUM_BINS:0]       fj_vld_reg;
    logic [ecdh_pkg::COUNT_WIDTH-1:0]  dj_rd_reg;
    logic [ecdh_pkg::COUNT_WIDTH-1:0]  fj_rd_reg;
    logic                              dj_rdv_reg;
    logic                              fj_rdv_reg;

    logic [ecdh_pkg::BIN_W-1:0]        dj_bin;
    logic [ecdh_pkg::BIN_W-1:0]        fj_bin;
    logic [ecdh_pkg::BIN_W-1:0]        dj_addr;
    logic [ecdh_pkg::BIN_W-1:0]        fj_addr;
    logic [ecdh_pkg::BIN_W-1:0]        rd_addr;
    logic                              rbin_ok;
    logic [ecdh_pkg::COUNT_WIDTH-1:0]  dj_cur;
    logic [ecdh_pkg::COUNT_WIDTH-1:0]  fj_cur;
    logic                              div_step;
    logic                              rd_en;
    logic                              wr_en;
    logic                              clr;
    logic                              out_load;
    logic                              is_count;

    // Bin dividers, one per histogram
    ecdh_bindiv u_dj_div (
        .aclk     (aclk),
        .start    (q_pop),
        .step     (div_step),
        .mass     (q_cmd.avg_dijet_mass),
        .res_mass (cfg.dijet_res_mass),
        .bin      (dj_bin)
    );

    ecdh_bindiv u_fj_div (
        .aclk     (aclk),
        .start    (q_pop),
        .step     (div_step),
        .mass     (q_cmd.fourjet_mass),
        .res_mass (cfg.fourjet_res_mass),
        .bin      (fj_bin)
    );

    // Control strobes and memory addressing
    always_comb begin
        is_count = (cmd_reg.kind == ecdh_pkg::CMD_COUNT);
        q_pop    = (state_reg == ST_IDLE) && !q_empty;
        div_step = (state_reg == ST_DIV);
        rd_en    = (state_reg == ST_MRD);
        wr_en    = (state_reg == ST_MUSE) && is_count;
        clr      = q_pop && (q_cmd.kind == ecdh_pkg::CMD_CLEAR);
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
        rbin_ok  = (int'(cmd_reg.read_bin) <= ecdh_pkg::NUM_BINS);
        rd_addr  = rbin_ok ? ecdh_pkg::BIN_W'(cmd_reg.read_bin) : '0;
        dj_addr  = is_count ? dj_bin : rd_addr;
        fj_addr  = is_count ? fj_bin : rd_addr;
        dj_cur   = dj_rdv_reg ? dj_rd_reg : '0;
        fj_cur   = fj_rdv_reg ? fj_rd_reg : '0;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_cmd.kind)
                        ecdh_pkg::CMD_COUNT: state_next = ST_DIV;
                        ecdh_pkg::CMD_READ:  state_next = ST_MRD;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_MRD;
                end
            end
            ST_MRD: begin
                state_next = ST_MUSE;
            end
            ST_MUSE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command, step count and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg  <= q_cmd;
            step_reg <= ecdh_pkg::STEP_W'(ecdh_pkg::BIN_W - 1);
            res_reg  <= '0;
        end else begin
            if (div_step) begin
                step_reg <= step_reg - 1'b1;
            end
            if (state_reg == ST_MUSE) begin
                if (is_count) begin
                    res_reg.accepted    <= 1'b1;
                    res_reg.dijet_bin   <= dj_bin;
                    res_reg.fourjet_bin <= fj_bin;
                end else if (cmd_reg.kind == ecdh_pkg::CMD_READ && rbin_ok) begin
                    res_reg.bin_count <= ecdh_pkg::sat_out(cmd_reg.which_hist ? fj_cur : dj_cur);
                end
            end
        end
    end

    // Histogram memories: registered read, write back the bumped count
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            dj_rd_reg  <= dj_mem[dj_addr];
            fj_rd_reg  <= fj_mem[fj_addr];
            dj_rdv_reg <= dj_vld_reg[dj_addr];
            fj_rdv_reg <= fj_vld_reg[fj_addr];
        end
        if (wr_en) begin
            dj_mem[dj_addr] <= ecdh_pkg::sat_inc(dj_cur);
            fj_mem[fj_addr] <= ecdh_pkg::sat_inc(fj_cur);
        end
    end

    // Entry valid bits; an empty entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dj_vld_reg <= '0;
            fj_vld_reg <= '0;
        end else if (clr) begin
            dj_vld_reg <= '0;
            fj_vld_reg <= '0;
        end else if (wr_en) begin
            dj_vld_reg[dj_addr] <= 1'b1;
            fj_vld_reg[fj_addr] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== rtl/event_cut_dual_histogram.sv =====
// A passing event runs the serial bin divider (one quotient bit per cycle over 7 bits),
// then the histogram read-modify-write; a read does the histogram read only, and
// rejects and clears go straight to the result. The back end takes one command at a
// time; the front end and queue keep taking items while the back end works.
// Reset (aresetn low, synchronous): registers to defaults, all histogram bins empty.
// ----------------------------------------------------------------------------
// Event cut dual histogram: top level
// Cuts each event, bins passing events into a dijet and a four-jet mass
// histogram, and serves bin reads and clears.
// ----------------------------------------------------------------------------
`include "event_cut_dual_histogram_defines.svh"

module event_cut_dual_histogram (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [ecdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ecdh_pkg::CFG_W-1:0]         cfg_wdata,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fourjet_mass[15:0], avg_dijet_mass[31:16], mass_asymmetry[47:32],
    // eta_gap[63:48], sep_first[79:64], sep_second[95:80], read_bin[102:96]
    input  logic [ecdh_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[1:0], which_hist[2]
    input  logic [ecdh_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // dijet_bin[6:0], fourjet_bin[13:7], bin_count[45:14]
    output logic [ecdh_pkg::M_TDATA_W-1:0]     m_tdata,
    // accepted[0]
    output logic                               m_tuser
);

    ecdh_pkg::cfg_t     cfg_reg;
    ecdh_pkg::item_t    s_item;
    ecdh_pkg::cmd_t     push_cmd;
    ecdh_pkg::cmd_t     pop_cmd;
    ecdh_pkg::result_t  m_result;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.asym_limit       <= 16'd410;
            cfg_reg.eta_gap_limit    <= 16'd4506;
            cfg_reg.separation_limit <= 16'd8192;
            cfg_reg.alpha_low        <= 16'd6554;
            cfg_reg.alpha_high       <= 16'd22282;
            cfg_reg.dijet_res_mass   <= 16'd2000;
            cfg_reg.fourjet_res_mass <= 16'd8000;
        end else if (cfg_we) begin
            unique case (ecdh_pkg::cfg_index_t'(cfg_index))
                ecdh_pkg::CFG_ASYM_LIMIT:  cfg_reg.asym_limit       <= cfg_wdata;
                ecdh_pkg::CFG_ETA_GAP:     cfg_reg.eta_gap_limit    <= cfg_wdata;
                ecdh_pkg::CFG_SEPARATION:  cfg_reg.separation_limit <= cfg_wdata;
                ecdh_pkg::CFG_ALPHA_LOW:   cfg_reg.alpha_low        <= cfg_wdata;
                ecdh_pkg::CFG_ALPHA_HIGH:  cfg_reg.alpha_high       <= cfg_wdata;
                ecdh_pkg::CFG_DIJET_RES:   cfg_reg.dijet_res_mass   <= cfg_wdata;
                ecdh_pkg::CFG_FOURJET_RES: cfg_reg.fourjet_res_mass <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input item
    always_comb begin
        s_item.action         = ecdh_pkg::action_t'(s_tuser[1:0]);
        s_item.which_hist     = s_tuser[2];
        s_item.fourjet_mass   = s_tdata[15:0];
        s_item.avg_dijet_mass = s_tdata[31:16];
        s_item.mass_asymmetry = s_tdata[47:32];
        s_item.eta_gap        = s_tdata[63:48];
        s_item.sep_first      = s_tdata[79:64];
        s_item.sep_second     = s_tdata[95:80];
        s_item.read_bin       = s_tdata[102:96];
    end

    ecdh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    ecdh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_cmd),
        .empty   (q_empty)
    );

    ecdh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // Pack the result item
    assign m_tdata = {2'b00, m_result.bin_count, m_result.fourjet_bin, m_result.dijet_bin};
    assign m_tuser = m_result.accepted;

    // Checks
    `ECDH_ASSERT(a_queue_no_overflow, q_push |-> !q_full, "command queue pushed while full")
    `ECDH_ASSERT(a_queue_no_underflow, q_pop |-> !q_empty, "command queue popped while empty")
    `ECDH_ASSERT(a_event_bins_range, (m_tvalid && m_result.accepted) |-> ((m_result.dijet_bin <= ecdh_pkg::BIN_W'(ecdh_pkg::NUM_BINS)) && (m_result.fourjet_bin <= ecdh_pkg::BIN_W'(ecdh_pkg::NUM_BINS)) && (m_result.bin_count == '0)), "counted event with bad bin or nonzero count")
    `ECDH_ASSERT_ALWAYS(a_reset_no_output, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
